// File: hw/rtl/prs_pkg.sv
package prs_pkg;

  localparam int unsigned RING_DEPTH = 4;
  localparam int unsigned RING_IDX_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int unsigned SUM_W      = 16 + $clog2(RING_DEPTH);

  localparam int unsigned SAMPLE_W = 18;
  localparam int unsigned TIME_W   = 32;
  localparam int unsigned AVG_W    = 26;
  localparam int unsigned RATE_W   = 16;
  localparam int unsigned THR_W    = 18;
  localparam int unsigned ALPHA_W  = 9;
  localparam int unsigned BLEND_W  = 25;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 18;

  // shared serial divider
  localparam int unsigned DIVD_W    = 30;
  localparam int unsigned DIVS_W    = 11;
  localparam int unsigned DIV_CNT_W = $clog2(DIVD_W);

  localparam int unsigned IR_DIVISOR      = 10;
  localparam int unsigned IR_ROUND        = 5;
  localparam int unsigned RATE_NUM        = 15360000;
  localparam int unsigned MIN_INTERVAL_MS = 300;
  localparam int unsigned MAX_INTERVAL_MS = 2000;
  localparam int unsigned RATE_MIN        = 45 * 256;
  localparam int unsigned RATE_MAX        = 150 * 256;
  localparam int unsigned FAST_BAND       = 5 * 256;
  localparam int unsigned SLOW_BAND       = 15 * 256;
  localparam int unsigned ALPHA_ONE       = 256;
  localparam int unsigned BLEND_ROUND     = 128;

  localparam int unsigned THR_RESET        = 50000;
  localparam int unsigned ALPHA_FAST_RESET = 77;
  localparam int unsigned ALPHA_SLOW_RESET = 26;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FINGER_THRESHOLD = 2'd0,
    CFG_ALPHA_FAST       = 2'd1,
    CFG_ALPHA_SLOW       = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic              start;
    logic [DIVD_W-1:0] dividend;
    logic [DIVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DIVD_W-1:0] quotient;
  } div_rsp_t;

endpackage

// File: hw/rtl/prs_div.sv
module prs_div (
  input  logic              clk,
  input  logic              rst_n,
  input  prs_pkg::div_req_t req,
  output prs_pkg::div_rsp_t rsp
);
  import prs_pkg::*;

  logic                 busy_r;
  logic                 done_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [DIVD_W-1:0]    q_r;
  logic [DIVS_W-1:0]    rem_r;
  logic [DIVS_W-1:0]    dvs_r;

  logic [DIVS_W:0]      rem_sh;
  logic                 ge;
  logic [DIVS_W:0]      rem_sub;

  // restoring division, one quotient bit per cycle
  assign rem_sh  = {rem_r, q_r[DIVD_W-1]};
  assign ge      = rem_sh >= {1'b0, dvs_r};
  assign rem_sub = rem_sh - {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        q_r    <= req.dividend;
        rem_r  <= '0;
        dvs_r  <= req.divisor;
      end else if (busy_r) begin
        q_r   <= {q_r[DIVD_W-2:0], ge};
        rem_r <= ge ? rem_sub[DIVS_W-1:0] : rem_sh[DIVS_W-1:0];
        if (cnt_r == DIV_CNT_W'(DIVD_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r + 1'b1;
        end
      end
    end
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = q_r;

endmodule

// File: hw/rtl/pulse_rate_smoother_unit.sv
// pulse_rate_smoother_unit
// Input channel: one IR sample, beat flag and millisecond timestamp per beat
// (in_valid / in_stall). Result channel: finger_present and the smoothed
// rate bpm in UQ8.8 (out_valid / out_stall), exactly one result per input.
// Config channel: cfg_valid / cfg_ready with cfg_index 0 finger threshold,
// 1 alpha_fast, 2 alpha_slow; cfg_ready is always high. Write only when idle.
// The IR, rate and mean divisions run through one shared restoring divider
// that yields one quotient bit per cycle. A sample with no counted beat
// takes the IR divide and the finger check; a beat whose rate is out of
// range adds the rate divide; a rate that enters the ring adds a serial
// ring sum, the mean divide and the blend (the blend multiply is skipped
// when the smoothed rate loads directly or the change is too large).
// in_stall is high while a sample is in work; the next sample can be taken
// in the cycle after the result is registered.
// The result sits in an output register, so a new sample is taken while the
// previous result waits; if the receiver stalls past the end of the next
// sample's work, that result waits in the done state and input stays stalled.
// Reset (rst_n low, synchronous) clears the IR average, last beat time, the
// rate ring, the smoothed rate and restores the register defaults.
module pulse_rate_smoother_unit (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [prs_pkg::SAMPLE_W-1:0]     in_ir_sample,
  input  logic                             in_beat,
  input  logic [prs_pkg::TIME_W-1:0]       in_time_ms,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             out_finger_present,
  output logic [prs_pkg::RATE_W-1:0]       out_bpm,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [prs_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [prs_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import prs_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_IR_DIV,
    ST_FINGER,
    ST_RATE_DIV,
    ST_SUM,
    ST_MEAN_DIV,
    ST_BLEND_SEL,
    ST_BLEND_MUL,
    ST_DONE
  } state_t;

  state_t                state_r;
  logic [THR_W-1:0]      thr_r;
  logic [ALPHA_W-1:0]    afast_r;
  logic [ALPHA_W-1:0]    aslow_r;
  logic [AVG_W-1:0]      avg_r;
  logic [TIME_W-1:0]     last_r;
  logic [RATE_W-1:0]     ring_r [RING_DEPTH];
  logic [RING_IDX_W-1:0] idx_r;
  logic [RATE_W-1:0]     smooth_r;
  logic                  beat_r;
  logic [TIME_W-1:0]     time_r;
  logic                  fing_r;
  logic [SUM_W-1:0]      sum_r;
  logic [RING_IDX_W-1:0] cnt_r;
  logic [RATE_W-1:0]     mean_r;
  logic [ALPHA_W-1:0]    alpha_r;
  logic [BLEND_W-1:0]    prod_r;
  div_req_t              div_req_r;
  div_rsp_t              div_rsp;
  logic                  out_valid_r;
  logic                  out_fp_r;
  logic [RATE_W-1:0]     out_bpm_r;

  logic [DIVD_W-1:0]     ir_blend;
  logic [TIME_W-1:0]     delta;
  logic                  delta_ok;
  logic                  finger;
  logic [DIVD_W-1:0]     rate_q;
  logic                  rate_ok;
  logic [SUM_W-1:0]      sum_nxt;
  logic [RATE_W-1:0]     diff;
  logic [BLEND_W-1:0]    prod_nxt;
  logic                  div_start_nxt;
  logic                  out_load;
  logic                  out_valid_nxt;

  function automatic logic [ALPHA_W-1:0] sat_alpha(input logic [ALPHA_W-1:0] a);
    return (a > ALPHA_W'(ALPHA_ONE)) ? ALPHA_W'(ALPHA_ONE) : a;
  endfunction

  prs_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req_r),
    .rsp   (div_rsp)
  );

  assign ir_blend = DIVD_W'({avg_r, 3'b000}) + DIVD_W'(avg_r)
                  + DIVD_W'({in_ir_sample, 8'h00}) + DIVD_W'(IR_ROUND);
  assign finger   = avg_r > {thr_r, 8'h00};
  assign delta    = time_r - last_r;
  assign delta_ok = (delta >= TIME_W'(MIN_INTERVAL_MS)) && (delta <= TIME_W'(MAX_INTERVAL_MS));
  assign rate_q   = div_rsp.quotient;
  assign rate_ok  = (rate_q >= DIVD_W'(RATE_MIN)) && (rate_q <= DIVD_W'(RATE_MAX));
  assign sum_nxt  = sum_r + SUM_W'(ring_r[cnt_r]);
  assign diff     = (mean_r >= smooth_r) ? (mean_r - smooth_r) : (smooth_r - mean_r);
  assign prod_nxt = prod_r
                  + BLEND_W'(ALPHA_W'(ALPHA_ONE) - alpha_r) * BLEND_W'(smooth_r)
                  + BLEND_W'(BLEND_ROUND);

  assign div_start_nxt = ((state_r == ST_IDLE) && in_valid)
                       || ((state_r == ST_FINGER) && finger && beat_r && delta_ok)
                       || ((state_r == ST_SUM) && (cnt_r == RING_IDX_W'(RING_DEPTH - 1)));
  assign out_load      = (state_r == ST_DONE) && (!out_valid_r || !out_stall);
  assign out_valid_nxt = out_load || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      thr_r       <= THR_W'(THR_RESET);
      afast_r     <= ALPHA_W'(ALPHA_FAST_RESET);
      aslow_r     <= ALPHA_W'(ALPHA_SLOW_RESET);
      avg_r       <= '0;
      last_r      <= '0;
      for (int i = 0; i < RING_DEPTH; i++) ring_r[i] <= '0;
      idx_r       <= '0;
      smooth_r    <= '0;
      div_req_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      div_req_r.start <= div_start_nxt;
      out_valid_r     <= out_valid_nxt;

      if (cfg_valid) begin
        unique case (cfg_index)
          CFG_FINGER_THRESHOLD: thr_r   <= cfg_data[THR_W-1:0];
          CFG_ALPHA_FAST:       afast_r <= cfg_data[ALPHA_W-1:0];
          CFG_ALPHA_SLOW:       aslow_r <= cfg_data[ALPHA_W-1:0];
          default: ;
        endcase
      end

      unique case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            beat_r             <= in_beat;
            time_r             <= in_time_ms;
            div_req_r.dividend <= ir_blend;
            div_req_r.divisor  <= DIVS_W'(IR_DIVISOR);
            state_r            <= ST_IR_DIV;
          end
        end
        ST_IR_DIV: begin
          if (div_rsp.done) begin
            avg_r   <= div_rsp.quotient[AVG_W-1:0];
            state_r <= ST_FINGER;
          end
        end
        ST_FINGER: begin
          fing_r <= finger;
          if (!finger) begin
            smooth_r <= '0;
            state_r  <= ST_DONE;
          end else if (beat_r) begin
            last_r <= time_r;
            if (delta_ok) begin
              div_req_r.dividend <= DIVD_W'(RATE_NUM) + DIVD_W'(delta[DIVS_W-1:1]);
              div_req_r.divisor  <= delta[DIVS_W-1:0];
              state_r            <= ST_RATE_DIV;
            end else begin
              state_r <= ST_DONE;
            end
          end else begin
            state_r <= ST_DONE;
          end
        end
        ST_RATE_DIV: begin
          if (div_rsp.done) begin
            if (rate_ok) begin
              ring_r[idx_r] <= rate_q[RATE_W-1:0];
              idx_r         <= (idx_r == RING_IDX_W'(RING_DEPTH - 1)) ? '0 : idx_r + 1'b1;
              sum_r         <= '0;
              cnt_r         <= '0;
              state_r       <= ST_SUM;
            end else begin
              state_r <= ST_DONE;
            end
          end
        end
        ST_SUM: begin
          sum_r <= sum_nxt;
          if (cnt_r == RING_IDX_W'(RING_DEPTH - 1)) begin
            div_req_r.dividend <= DIVD_W'(sum_nxt);
            div_req_r.divisor  <= DIVS_W'(RING_DEPTH);
            state_r            <= ST_MEAN_DIV;
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
        ST_MEAN_DIV: begin
          if (div_rsp.done) begin
            mean_r  <= div_rsp.quotient[RATE_W-1:0];
            state_r <= ST_BLEND_SEL;
          end
        end
        ST_BLEND_SEL: begin
          priority if (smooth_r == '0) begin
            smooth_r <= mean_r;
            state_r  <= ST_DONE;
          end else if (diff < RATE_W'(FAST_BAND)) begin
            alpha_r <= sat_alpha(afast_r);
            prod_r  <= BLEND_W'(sat_alpha(afast_r)) * BLEND_W'(mean_r);
            state_r <= ST_BLEND_MUL;
          end else if (diff < RATE_W'(SLOW_BAND)) begin
            alpha_r <= sat_alpha(aslow_r);
            prod_r  <= BLEND_W'(sat_alpha(aslow_r)) * BLEND_W'(mean_r);
            state_r <= ST_BLEND_MUL;
          end else begin
            state_r <= ST_DONE;
          end
        end
        ST_BLEND_MUL: begin
          smooth_r <= prod_nxt[RATE_W+7:8];
          state_r  <= ST_DONE;
        end
        ST_DONE: begin
          if (out_load) begin
            out_fp_r  <= fing_r;
            out_bpm_r <= smooth_r;
            state_r   <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign in_stall           = (state_r != ST_IDLE);
  assign cfg_ready          = 1'b1;
  assign out_valid          = out_valid_r;
  assign out_finger_present = out_fp_r;
  assign out_bpm            = out_bpm_r;

endmodule

// File: hw/rtl/prs_checker.sv
module prs_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_valid,
  input logic                           in_stall,
  input logic                           out_valid,
  input logic                           out_stall,
  input logic                           out_finger_present,
  input logic [prs_pkg::RATE_W-1:0]     out_bpm
);
  import prs_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=>
      out_valid && $stable(out_bpm) && $stable(out_finger_present))
    else $error("stalled result beat changed");

  a_no_finger_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_finger_present |-> out_bpm == '0)
    else $error("nonzero rate without finger");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("block not idle after reset");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken again right after a beat");

endmodule

bind pulse_rate_smoother_unit prs_checker u_prs_checker (.*);

// File: bench/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import prs_pkg::*;

  typedef struct packed {
    logic              finger_present;
    logic [RATE_W-1:0] bpm;
  } pulse_reading_t;

  logic                  clk          = 1'b0;
  logic                  rst_n        = 1'b0;
  logic                  in_valid     = 1'b0;
  logic                  in_stall;
  logic [SAMPLE_W-1:0]   in_ir_sample = '0;
  logic                  in_beat      = 1'b0;
  logic [TIME_W-1:0]     in_time_ms   = '0;
  logic                  out_valid;
  logic                  out_stall    = 1'b0;
  logic                  out_finger_present;
  logic [RATE_W-1:0]     out_bpm;
  logic                  cfg_valid    = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index    = '0;
  logic [CFG_DATA_W-1:0] cfg_data     = '0;

  // predictor copy of registers and state
  logic [THR_W-1:0]   thr_m        = THR_W'(THR_RESET);
  logic [ALPHA_W-1:0] alpha_fast_m = ALPHA_W'(ALPHA_FAST_RESET);
  logic [ALPHA_W-1:0] alpha_slow_m = ALPHA_W'(ALPHA_SLOW_RESET);
  logic [AVG_W-1:0]   ir_avg_m     = '0;
  logic [TIME_W-1:0]  last_beat_ms = '0;
  logic [RATE_W-1:0]  rate_hist [RING_DEPTH] = '{default: '0};
  int unsigned        hist_pos     = 0;
  logic [RATE_W-1:0]  smooth_bpm   = '0;

  pulse_reading_t    pulse_due_q[$];
  pulse_reading_t    due;
  int unsigned       mismatches = 0;
  bit                idle_on    = 1'b1;
  int unsigned       calm_left  = 0;
  logic [TIME_W-1:0] now_ms     = '0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  pulse_rate_smoother_unit u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_ir_sample       (in_ir_sample),
    .in_beat            (in_beat),
    .in_time_ms         (in_time_ms),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_finger_present (out_finger_present),
    .out_bpm            (out_bpm),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  function automatic pulse_reading_t smooth_pulse_step(logic [SAMPLE_W-1:0] ir, logic beat,
                                                       logic [TIME_W-1:0] stamp);
    pulse_reading_t    r;
    longint unsigned   acc, sum, mean, diff, alpha, rate;
    logic [TIME_W-1:0] gap;
    acc = 9 * longint'(ir_avg_m) + 256 * longint'(ir) + 64'(IR_ROUND);
    ir_avg_m = AVG_W'(acc / IR_DIVISOR);
    r.finger_present = ir_avg_m > {thr_m, 8'd0};
    if (!r.finger_present) begin
      smooth_bpm = '0;
    end else if (beat) begin
      gap = stamp - last_beat_ms;
      last_beat_ms = stamp;
      if (gap >= MIN_INTERVAL_MS && gap <= MAX_INTERVAL_MS) begin
        rate = 64'((RATE_NUM + gap / 2) / gap);
        if (rate >= RATE_MIN && rate <= RATE_MAX) begin
          rate_hist[hist_pos] = RATE_W'(rate);
          hist_pos = (hist_pos + 1) % RING_DEPTH;
          sum = 0;
          foreach (rate_hist[i]) sum += 64'(rate_hist[i]);
          mean = sum / RING_DEPTH;
          if (smooth_bpm == 0) begin
            smooth_bpm = RATE_W'(mean);
          end else begin
            diff = (mean > smooth_bpm) ? mean - smooth_bpm : smooth_bpm - mean;
            if (diff < SLOW_BAND) begin
              alpha = (diff < FAST_BAND) ? 64'(alpha_fast_m) : 64'(alpha_slow_m);
              if (alpha > ALPHA_ONE) alpha = 64'(ALPHA_ONE);
              smooth_bpm = RATE_W'((alpha * mean + (ALPHA_ONE - alpha) * smooth_bpm
                                    + BLEND_ROUND) >> 8);
            end
          end
        end
      end
    end
    r.bpm = smooth_bpm;
    return r;
  endfunction

  task automatic send_pulse(logic [SAMPLE_W-1:0] ir, logic beat, logic [TIME_W-1:0] stamp);
    if (calm_left > 0) begin
      calm_left--;
    end else if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end else if ($urandom_range(0, 30) == 0) begin
      calm_left = $urandom_range(10, 40);
    end
    in_valid     <= 1'b1;
    in_ir_sample <= ir;
    in_beat      <= beat;
    in_time_ms   <= stamp;
    do @(posedge clk); while (in_stall !== 1'b0);
    pulse_due_q.push_back(smooth_pulse_step(ir, beat, stamp));
  endtask

  task automatic drain_pulses();
    in_valid <= 1'b0;
    while (pulse_due_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic apply_config(logic [CFG_DATA_W-1:0] thr, logic [CFG_DATA_W-1:0] fast_w,
                              logic [CFG_DATA_W-1:0] slow_w);
    cfg_idx_t              order [3] = '{CFG_FINGER_THRESHOLD, CFG_ALPHA_FAST, CFG_ALPHA_SLOW};
    logic [CFG_DATA_W-1:0] words [3];
    words = '{thr, fast_w, slow_w};
    for (int k = 0; k < 3; k++) begin
      cfg_valid <= 1'b1;
      cfg_index <= order[k];
      cfg_data  <= words[k];
      do @(posedge clk); while (cfg_ready !== 1'b1);
      case (order[k])
        CFG_FINGER_THRESHOLD: thr_m = words[k][THR_W-1:0];
        CFG_ALPHA_FAST:       alpha_fast_m = words[k][ALPHA_W-1:0];
        CFG_ALPHA_SLOW:       alpha_slow_m = words[k][ALPHA_W-1:0];
        default: ;
      endcase
    end
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // mostly finger-on beat trains around a drifting base interval, plus dropouts and noise
  task automatic run_rhythm(int unsigned n_items);
    logic [TIME_W-1:0]   base_ms;
    logic [SAMPLE_W-1:0] ir;
    logic                beat;
    int unsigned         dropout, roll, hi;
    dropout = 0;
    base_ms = $urandom_range(400, 1333);
    for (int unsigned k = 0; k < n_items; k++) begin
      roll = $urandom_range(0, 99);
      if (dropout == 0 && roll < 5) dropout = $urandom_range(3, 12);
      if (roll >= 95) begin
        base_ms = $urandom_range(400, 1333);
      end else if (roll >= 85) begin
        base_ms = base_ms + $urandom_range(0, 120) - 60;
        if (base_ms < 380) base_ms = 380;
        if (base_ms > 1400) base_ms = 1400;
      end
      beat = 1'($urandom_range(0, 1));
      if (dropout > 0) begin
        dropout--;
        ir = SAMPLE_W'($urandom_range(0, thr_m / 2));
        now_ms += $urandom_range(1, 40);
      end else if (roll < 15) begin
        ir = SAMPLE_W'($urandom_range(0, (1 << SAMPLE_W) - 1));
        if ($urandom_range(0, 3) == 0) now_ms = $urandom;
        else now_ms += $urandom_range(0, 2500);
      end else begin
        hi = thr_m + (thr_m >> 2) + 64 + $urandom_range(0, (thr_m >> 3) + 64);
        ir = (hi > (1 << SAMPLE_W) - 1) ? SAMPLE_W'((1 << SAMPLE_W) - 1) : SAMPLE_W'(hi);
        if (!beat) now_ms += $urandom_range(1, 40);
        else if ($urandom_range(0, 19) == 0) now_ms = last_beat_ms + $urandom_range(100, 2600);
        else now_ms = last_beat_ms + base_ms + $urandom_range(0, 40) - 20;
      end
      send_pulse(ir, beat, now_ms);
    end
    drain_pulses();
  endtask

  task automatic test_extremes();
    logic [TIME_W-1:0] stamp;
    send_pulse(18'd0, 1'b1, 32'd0);
    send_pulse(18'h3FFFF, 1'b0, 32'd5);
    send_pulse(18'h3FFFF, 1'b1, 32'd10);
    send_pulse(18'h3FFFF, 1'b0, 32'd15);
    send_pulse(18'd65000, 1'b1, 32'hFFFF_FFFF);
    stamp = 32'd299;                          // interval wraps through zero, rate too high
    send_pulse(18'd65000, 1'b1, stamp);
    stamp += 400;                             // rate exactly at the top
    send_pulse(18'd65000, 1'b1, stamp);
    stamp += 1333;
    send_pulse(18'd65000, 1'b1, stamp);
    stamp += 1334;
    send_pulse(18'd65000, 1'b1, stamp);
    stamp += 299;
    send_pulse(18'd65000, 1'b1, stamp);
    stamp += 2000;
    send_pulse(18'd65000, 1'b1, stamp);
    stamp += 2001;
    send_pulse(18'd65000, 1'b1, stamp);
    repeat (4) begin
      stamp += 800;
      send_pulse(18'd65000, 1'b1, stamp);
    end
    repeat (4) begin
      stamp += 5;
      send_pulse(18'd0, 1'b1, stamp);
    end
    stamp += 800;                             // finger back: rate loads from ring mean
    send_pulse(18'h3FFFF, 1'b1, stamp);
    stamp += 810;
    send_pulse(18'd65000, 1'b1, stamp);
    send_pulse(18'd65000, 1'b0, 32'd0);
    drain_pulses();
  endtask

  task automatic test_default_rhythm();
    apply_config(CFG_DATA_W'(THR_RESET), CFG_DATA_W'(ALPHA_FAST_RESET),
                 CFG_DATA_W'(ALPHA_SLOW_RESET));
    run_rhythm(200);
  endtask

  task automatic test_alpha_extremes();
    apply_config(CFG_DATA_W'(THR_RESET), 18'd0, CFG_DATA_W'(ALPHA_ONE));
    run_rhythm(120);
    apply_config(CFG_DATA_W'(THR_RESET), {9'h155, 9'h1FF}, {9'h0AA, 9'h101});
    run_rhythm(120);
  endtask

  task automatic test_threshold_extremes();
    apply_config(18'd0, 18'd128, 18'd200);
    run_rhythm(80);
    apply_config(18'h3FFFF, 18'd300, 18'd64);
    run_rhythm(40);
    apply_config(18'h3FFFE, 18'd256, 18'd1);
    run_rhythm(60);
  endtask

  task automatic test_random_config();
    repeat (3) begin
      apply_config(CFG_DATA_W'($urandom_range(0, (1 << CFG_DATA_W) - 1)),
                   CFG_DATA_W'($urandom_range(0, (1 << CFG_DATA_W) - 1)),
                   CFG_DATA_W'($urandom_range(0, (1 << CFG_DATA_W) - 1)));
      run_rhythm(70);
    end
  endtask

  task automatic test_steady_flow();
    idle_on = 1'b0;
    apply_config(CFG_DATA_W'(THR_RESET), CFG_DATA_W'(ALPHA_FAST_RESET),
                 CFG_DATA_W'(ALPHA_SLOW_RESET));
    run_rhythm(150);
  endtask

  initial begin
    forever begin
      @(posedge clk);
      if (idle_on && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 18)) @(posedge clk);
        out_stall <= 1'b0;
      end else if ($urandom_range(0, 40) == 0) begin
        repeat ($urandom_range(30, 200)) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (pulse_due_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result with nothing pending: finger %0b bpm %0d",
                   out_finger_present, out_bpm);
      end else begin
        due = pulse_due_q.pop_front();
        if (out_finger_present !== due.finger_present || out_bpm !== due.bpm) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch at %0t: finger exp %0b got %0b, bpm exp %0d got %0d",
                     $realtime, due.finger_present, out_finger_present, due.bpm, out_bpm);
        end
      end
    end
  end

  initial begin
    #20_000_000;
    $display("status: fail");
    $finish;
  end

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_extremes();
    test_default_rhythm();
    test_alpha_extremes();
    test_threshold_extremes();
    test_random_config();
    test_steady_flow();
    repeat (200) @(posedge clk);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
